>>> design/dvsd_pkg.sv
// Package for the delta varint stream decoder: widths, decode constants and
// the item and result structs used by the modules.
`default_nettype none

package dvsd_pkg;

    localparam int DATA_W       = 8;
    localparam int SUM_W        = 64;
    localparam int COUNT_BITS   = 40;
    localparam int ENTRY_W      = 40;
    localparam int LEN_W        = 4;
    localparam int STREAM_LEN_W = 40;
    localparam int GROUP_BITS   = 7;
    localparam int SHIFT_W      = $clog2(SUM_W);

    localparam logic [LEN_W-1:0] MAX_GROUPS = LEN_W'(10);
    localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(15);

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              restart;
    } t_item;

    typedef struct packed {
        logic [SUM_W-1:0]   running_sum;
        logic [ENTRY_W-1:0] entry_count;
        logic [LEN_W-1:0]   varint_length;
        logic               overflow;
    } t_result;

endpackage

`default_nettype wire

>>> design/dvsd_byte_if.sv
// Byte stream channel: valid/ready handshake carrying one stream byte
// and its restart mark. Depends on dvsd_pkg.
`default_nettype none

interface dvsd_byte_if;
    logic                        valid;
    logic                        ready;
    logic [dvsd_pkg::DATA_W-1:0] data_byte;
    logic                        restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

`default_nettype wire

>>> design/dvsd_result_if.sv
// Result channel: valid/ready handshake carrying one decoded entry.
// Depends on dvsd_pkg.
`default_nettype none

interface dvsd_result_if;
    logic                         valid;
    logic                         ready;
    logic [dvsd_pkg::SUM_W-1:0]   running_sum;
    logic [dvsd_pkg::ENTRY_W-1:0] entry_count;
    logic [dvsd_pkg::LEN_W-1:0]   varint_length;
    logic                         overflow;

    modport source (output valid, output running_sum, output entry_count,
                    output varint_length, output overflow, input ready);
    modport sink   (input valid, input running_sum, input entry_count,
                    input varint_length, input overflow, output ready);
endinterface

`default_nettype wire

>>> design/dvsd_core.sv
// Decode state and combinational step: folds one byte into the partial
// varint, closes the varint into the running sum. Depends on dvsd_pkg.
`default_nettype none

module dvsd_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_fire,
    input  wire dvsd_pkg::t_item                     i_item,
    input  wire logic [dvsd_pkg::STREAM_LEN_W-1:0]   i_stream_length,
    output logic                                     o_produce,
    output dvsd_pkg::t_result                        o_result
);

    logic [dvsd_pkg::SUM_W-1:0]        r_sum, n_sum;
    logic [dvsd_pkg::SUM_W-1:0]        r_partial, n_partial;
    logic [dvsd_pkg::LEN_W-1:0]        r_gi, n_gi;
    logic [dvsd_pkg::COUNT_BITS-1:0]   r_count, n_count;
    logic [dvsd_pkg::STREAM_LEN_W-1:0] r_left, n_left;
    logic                              r_skip, n_skip;
    logic                              r_ovf, n_ovf;

    logic [dvsd_pkg::SUM_W-1:0]        c_sum, c_partial, part_or;
    logic [dvsd_pkg::LEN_W-1:0]        c_gi, gi_inc;
    logic [dvsd_pkg::COUNT_BITS-1:0]   c_count, count_inc;
    logic [dvsd_pkg::STREAM_LEN_W-1:0] c_left;
    logic                              c_skip, c_ovf, more, skip, in_range;
    logic [dvsd_pkg::SHIFT_W-1:0]      shamt;
    logic [dvsd_pkg::LEN_W+2:0]        gi_x7;

    always_comb begin
        more = i_item.data_byte[dvsd_pkg::DATA_W-1];

        // Restart clears the stream state and reloads the byte budget before the byte is handled.
        c_sum     = i_item.restart ? '0 : r_sum;
        c_partial = i_item.restart ? '0 : r_partial;
        c_gi      = i_item.restart ? '0 : r_gi;
        c_count   = i_item.restart ? '0 : r_count;
        c_skip    = i_item.restart ? 1'b0 : r_skip;
        c_ovf     = i_item.restart ? 1'b0 : r_ovf;
        c_left    = i_item.restart ? i_stream_length : r_left;

        skip = c_skip || (c_gi == '0 && c_left == '0);

        // Group position times seven, as shift minus subtract.
        gi_x7    = {c_gi, 3'b000} - {3'b000, c_gi};
        shamt    = gi_x7[dvsd_pkg::SHIFT_W-1:0];
        in_range = c_gi < dvsd_pkg::MAX_GROUPS;
        part_or  = c_partial;
        if (in_range) begin
            part_or = c_partial |
                (dvsd_pkg::SUM_W'(i_item.data_byte[dvsd_pkg::GROUP_BITS-1:0]) << shamt);
        end
        gi_inc    = (c_gi < dvsd_pkg::LEN_MAX) ? c_gi + dvsd_pkg::LEN_W'(1) : c_gi;
        count_inc = c_count + dvsd_pkg::COUNT_BITS'(1);

        n_sum     = c_sum;
        n_partial = c_partial;
        n_gi      = c_gi;
        n_count   = c_count;
        n_left    = c_left;
        n_skip    = c_skip;
        n_ovf     = c_ovf;
        o_produce = 1'b0;

        if (skip) begin
            // Drop the whole varint; leave skip mode on its last byte.
            n_skip = more;
        end else begin
            n_ovf  = c_ovf || !in_range;
            n_left = (c_left != '0) ? c_left - dvsd_pkg::STREAM_LEN_W'(1) : c_left;
            if (more) begin
                n_partial = part_or;
                n_gi      = gi_inc;
            end else begin
                n_sum     = c_sum + part_or;
                n_count   = count_inc;
                n_partial = '0;
                n_gi      = '0;
                n_ovf     = 1'b0;
                o_produce = 1'b1;
            end
        end

        o_result.running_sum   = c_sum + part_or;
        o_result.entry_count   = dvsd_pkg::ENTRY_W'(count_inc);
        o_result.varint_length = gi_inc;
        o_result.overflow      = c_ovf || !in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_partial <= '0;
            r_gi      <= '0;
            r_count   <= '0;
            r_left    <= '1;
            r_skip    <= 1'b0;
            r_ovf     <= 1'b0;
        end else if (i_fire) begin
            r_sum     <= n_sum;
            r_partial <= n_partial;
            r_gi      <= n_gi;
            r_count   <= n_count;
            r_left    <= n_left;
            r_skip    <= n_skip;
            r_ovf     <= n_ovf;
        end
    end

    a_restart_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.restart && o_produce |-> o_result.entry_count == 1)
        else $error("first entry after restart not counted as one");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_produce |-> o_result.varint_length != '0)
        else $error("result with zero varint length");

    a_ovf_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_produce && o_result.overflow
            |-> o_result.varint_length > dvsd_pkg::MAX_GROUPS)
        else $error("overflow flagged on a short varint");

endmodule

`default_nettype wire

>>> design/dvsd_out_reg.sv
// Result register driving the result channel; loads when empty or drained.
// Depends on dvsd_pkg and dvsd_result_if.
`default_nettype none

module dvsd_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire dvsd_pkg::t_result i_data,
    output logic                   o_space,
    dvsd_result_if.source          o_res
);

    logic              r_valid;
    logic              n_valid;
    dvsd_pkg::t_result r_data;

    assign o_space = !r_valid || o_res.ready;
    assign n_valid = i_load || (r_valid && !o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.running_sum   = r_data.running_sum;
    assign o_res.entry_count   = r_data.entry_count;
    assign o_res.varint_length = r_data.varint_length;
    assign o_res.overflow      = r_data.overflow;

endmodule

`default_nettype wire

>>> design/delta_varint_stream_decoder.sv
// Top level of the delta varint stream decoder: input register, budget
// register and glue. Depends on dvsd_pkg, both channel interfaces, dvsd_core, dvsd_out_reg.
`default_nettype none

// Decodes a byte stream of unsigned little-endian base-128 varints (seven
// value bits per byte, bit 7 set means another byte follows) and adds each
// completed varint to a 64-bit running sum that wraps. One result
// transaction goes out per completed varint with the new sum, the entry
// count since the last restart, the varint length in bytes (saturating at
// 15) and an overflow flag for varints longer than ten bytes, whose extra
// groups are dropped. A byte marked restart clears sum and count and loads
// the byte budget from the stream_length register (written through
// i_cfg_we / i_cfg_wdata; the user writes it only while the block is
// idle, the block does not enforce this); varints that begin with the
// budget at zero are consumed with no result. Throughput is one byte per
// cycle while the step does not stall: every accepted byte is held in the
// input register, then a combinational step (shift, OR and 64-bit add)
// updates the decode state and loads the result register, from which the
// result is taken. The step stalls only when it must produce a result and
// the result register is full and not being taken; while a finished
// result waits, bytes that do not close a varint keep flowing.
module delta_varint_stream_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [dvsd_pkg::STREAM_LEN_W-1:0] i_cfg_wdata,
    dvsd_byte_if.sink                              i_byte,
    dvsd_result_if.source                          o_result
);

    // Byte budget loaded on restart.
    logic [dvsd_pkg::STREAM_LEN_W-1:0] r_stream_length;

    // Input register.
    logic            r_in_valid;
    dvsd_pkg::t_item r_item;

    logic              produce;
    logic              out_space;
    logic              adv;
    logic              in_fire;
    dvsd_pkg::t_result step_result;

    // Advance the held byte unless it would close a varint into a full,
    // stalled result register.
    assign adv          = r_in_valid && (!produce || out_space);
    assign i_byte.ready = !r_in_valid || adv;
    assign in_fire      = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_length <= '1;
        end else if (i_cfg_we) begin
            r_stream_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold payload; capture on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.data_byte <= i_byte.data_byte;
            r_item.restart   <= i_byte.restart;
        end
    end

    dvsd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (adv),
        .i_item          (r_item),
        .i_stream_length (r_stream_length),
        .o_produce       (produce),
        .o_result        (step_result)
    );

    dvsd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && produce),
        .i_data  (step_result),
        .o_space (out_space),
        .o_res   (o_result)
    );

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_byte.ready)
        else $error("input refused while input register empty");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_item))
        else $error("stalled byte lost from input register");

endmodule

`default_nettype wire
